// ===== design/ball_track_candidate_gate_unit_defines.svh =====
// Assertion macros used by the gate unit design file.
`ifndef BALL_TRACK_CANDIDATE_GATE_UNIT_DEFINES_SVH
`define BALL_TRACK_CANDIDATE_GATE_UNIT_DEFINES_SVH

// Concurrent property check, evaluated at every clock edge outside reset.
`define BTCG_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition in one cycle implies a consequence in the next cycle.
`define BTCG_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/btcg_pkg.sv =====
package btcg_pkg;

  localparam int STEP_WINDOW_DEF   = 5;
  localparam int RADIUS_WINDOW_DEF = 3;

  localparam int TOP_MARGIN    = 80;
  localparam int STEP_FACTOR   = 5;
  localparam int RADIUS_FACTOR = 2;

  localparam int ADDR_W = 5;

  localparam int CORDIC_STEPS = 16;
  localparam int ANG_W        = 27;
  localparam int CXY_W        = 28;

  localparam logic signed [ANG_W-1:0] DEG180 = 27'sd11796480;

  localparam logic signed [ANG_W-1:0] CORDIC_TAB [CORDIC_STEPS] = '{
    27'sd2949120, 27'sd1740967, 27'sd919879, 27'sd466945,
    27'sd234379,  27'sd117304,  27'sd58666,  27'sd29335,
    27'sd14668,   27'sd7334,    27'sd3667,   27'sd1833,
    27'sd917,     27'sd458,     27'sd229,    27'sd115
  };

  localparam logic [15:0] ANGLE_TOL_RST   = 16'd512;
  localparam logic [15:0] DIST_MARGIN_RST = 16'd80;
  localparam logic [3:0]  MISS_LIMIT_RST  = 4'd3;
  localparam logic [3:0]  MISS_MAX        = 4'd15;

  typedef enum logic [2:0] {
    REG_START_X,
    REG_START_Y,
    REG_REF_X,
    REG_REF_Y,
    REG_ANGLE_TOL,
    REG_DIST_MARGIN,
    REG_MISS_LIMIT
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_REF_GO,
    ST_REF_WAIT,
    ST_CAND_GO,
    ST_CAND_WAIT,
    ST_MED,
    ST_DECIDE,
    ST_FEND,
    ST_STEP_WAIT,
    ST_HIST,
    ST_SUM,
    ST_DIV,
    ST_OUT
  } state_t;

endpackage

// ===== design/btcg_item_if.sv =====
interface btcg_item_if;
  logic        valid;
  logic        ready;
  logic [15:0] cand_x;
  logic [15:0] cand_y;
  logic [15:0] cand_radius;
  logic        cand_present;
  logic        frame_end;

  modport source (output valid, cand_x, cand_y, cand_radius, cand_present, frame_end,
                  input ready);
  modport sink (input valid, cand_x, cand_y, cand_radius, cand_present, frame_end,
                output ready);
endinterface

// ===== design/btcg_result_if.sv =====
interface btcg_result_if;
  logic        valid;
  logic        ready;
  logic [15:0] track_x;
  logic [15:0] track_y;
  logic        ball_found;
  logic [15:0] chosen_radius;
  logic        tracking_over;

  modport source (output valid, track_x, track_y, ball_found, chosen_radius, tracking_over,
                  input ready);
  modport sink (input valid, track_x, track_y, ball_found, chosen_radius, tracking_over,
                output ready);
endinterface

// ===== design/btcg_cordic.sv =====
module btcg_cordic (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic signed [16:0]               a,
  input  logic signed [16:0]               b,
  output logic                             busy,
  output logic signed [btcg_pkg::ANG_W-1:0] angle
);
  import btcg_pkg::*;

  logic signed [CXY_W-1:0] x, y, xs, ys, ae, be;
  logic signed [ANG_W-1:0] z;
  logic [3:0]              step;

  assign ae = CXY_W'(a) <<< 8;
  assign be = CXY_W'(b) <<< 8;
  assign xs = x >>> step;
  assign ys = y >>> step;
  assign angle = z;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      step <= '0;
      busy <= !(a == 17'sd0 && b == 17'sd0);
      if (a == 17'sd0 && b == 17'sd0) begin
        z <= '0;
      end else if (b < 17'sd0) begin
        // Rotate into the right half plane first.
        x <= -be;
        y <= -ae;
        z <= (a >= 17'sd0) ? DEG180 : -DEG180;
      end else begin
        x <= be;
        y <= ae;
        z <= '0;
      end
    end else if (busy) begin
      step <= step + 4'd1;
      if (y > 0) begin
        x <= x + ys;
        y <= y - xs;
        z <= z + CORDIC_TAB[step];
      end else begin
        x <= x - ys;
        y <= y + xs;
        z <= z - CORDIC_TAB[step];
      end
      if (step == 4'(CORDIC_STEPS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

// ===== design/btcg_isqrt.sv =====
module btcg_isqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [15:0] x1,
  input  logic [15:0] y1,
  input  logic [15:0] x2,
  input  logic [15:0] y2,
  output logic        busy,
  output logic [15:0] root
);
  localparam logic [4:0] CNT_SQ_DX = 5'd18;
  localparam logic [4:0] CNT_SQ_DY = 5'd17;

  logic [15:0] dx, dy, mop;
  logic [31:0] prod;
  logic [33:0] n, res, bitv, trial;
  logic [4:0]  cnt;

  // One multiplier squares dx, then dy; the root is then built two bits of n a cycle.
  assign mop   = (cnt == CNT_SQ_DX) ? dx : dy;
  assign prod  = mop * mop;
  assign bitv  = 34'd1 << {cnt, 1'b0};
  assign trial = res + bitv;
  assign root  = (|res[33:16]) ? 16'hFFFF : res[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_SQ_DX;
      dx   <= (x1 >= x2) ? x1 - x2 : x2 - x1;
      dy   <= (y1 >= y2) ? y1 - y2 : y2 - y1;
      res  <= '0;
    end else if (busy) begin
      cnt <= cnt - 5'd1;
      if (cnt == CNT_SQ_DX) begin
        n <= 34'(prod);
      end else if (cnt == CNT_SQ_DY) begin
        n <= n + 34'(prod);
      end else begin
        if (n >= trial) begin
          n   <= n - trial;
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        if (cnt == 5'd0) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

// ===== design/ball_track_candidate_gate_unit.sv =====
// Ball track candidate gate. Blob candidates arrive one beat each on the item channel,
// grouped into frames by frame_end; every frame end yields one result beat with the new
// track point, or the held point when no candidate passed the gates. The block takes one
// item at a time. For each candidate beat a 16-step CORDIC and a square root run side
// by side, once for the start-reference pair and once for the candidate, and the
// square root sets the pace; once more than STEP_WINDOW steps are recorded, a sweep of
// the step history for its median follows. At a frame end the step length needs one
// more square root when a candidate was kept, and the mean radius comes from a
// reciprocal multiply. An empty item that does not end a frame is taken and dropped.
// The result sits in an output register, so a pending result beat only holds the
// block when the next result is ready to be written. Writing start_x or start_y
// restarts the track; after the miss limit is reached every item is dropped until
// such a restart or reset.
`include "ball_track_candidate_gate_unit_defines.svh"

module ball_track_candidate_gate_unit #(
  parameter int STEP_WINDOW   = btcg_pkg::STEP_WINDOW_DEF,
  parameter int RADIUS_WINDOW = btcg_pkg::RADIUS_WINDOW_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  btcg_item_if.sink                   item,
  btcg_result_if.source               result,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [btcg_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import btcg_pkg::*;

  localparam int SC_W   = $clog2(STEP_WINDOW + 2);
  localparam int SI_W   = $clog2(STEP_WINDOW);
  localparam int RK_W   = $clog2(STEP_WINDOW + 1);
  localparam int RC_W   = $clog2(RADIUS_WINDOW + 1);
  localparam int SUM_W  = 16 + $clog2(RADIUS_WINDOW);
  localparam int DIV_K  = SUM_W + 4;
  localparam logic [DIV_K:0] DIV_RECIP = (DIV_K+1)'(
    ((longint'(1) << DIV_K) + longint'(RADIUS_WINDOW) - 1) / longint'(RADIUS_WINDOW));
  localparam int MID_LO = (STEP_WINDOW - 1) / 2;
  localparam int MID_HI = STEP_WINDOW / 2;

  // Configuration.
  logic [15:0] start_x, start_y, ref_x, ref_y, angle_tol, dist_margin;
  logic [3:0]  miss_limit;
  logic        wr, wr_restart;
  reg_idx_t    widx;

  // Track state.
  logic [15:0]     last_x, last_y, mean_radius, best_radius, best_x, best_y;
  logic [15:0]     step_hist [STEP_WINDOW];
  logic [15:0]     rad_hist  [RADIUS_WINDOW];
  logic [SC_W-1:0] step_count;
  logic [RC_W-1:0] radius_count;
  logic [3:0]      miss_count;
  logic            halted;

  // Item and work registers.
  logic [15:0]              cx, cy, cr, dref, med_lo, med_hi;
  logic                     cpres, cfend;
  logic signed [ANG_W-1:0]  zref;
  logic [SI_W-1:0]          med_idx;
  logic [SUM_W-1:0]         dv, rsum;
  logic [SUM_W+DIV_K:0]     quot_prod;

  state_t state, state_next;

  // Shared units.
  logic                     cordic_start, cordic_busy, sqrt_start, sqrt_busy, units_idle;
  logic [15:0]              cord_px, cord_py, sq_x1, sq_y1, sq_x2, sq_y2, sqrt_root;
  logic signed [16:0]       cord_a, cord_b;
  logic signed [ANG_W-1:0]  cord_angle;

  // Decision signals.
  logic                     found, keep, over, result_load, med_last;
  logic                     g_top, g_ang, g_max, g_med, g_rad, g_y;
  logic signed [ANG_W:0]    dz;
  logic [ANG_W:0]           adz;
  logic [16:0]              med;
  logic [15:0]              sj;
  logic [RK_W-1:0]          lt_cnt, le_cnt;
  logic [3:0]               lim;

  // ---------------- configuration port ----------------
  assign pready     = 1'b1;
  assign wr         = psel && penable && pwrite;
  assign widx       = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr_restart = wr && (widx == REG_START_X || widx == REG_START_Y);

  always_ff @(posedge clk) begin
    if (rst) begin
      start_x     <= '0;
      start_y     <= '0;
      ref_x       <= '0;
      ref_y       <= '0;
      angle_tol   <= ANGLE_TOL_RST;
      dist_margin <= DIST_MARGIN_RST;
      miss_limit  <= MISS_LIMIT_RST;
    end else if (wr) begin
      unique case (widx)
        REG_START_X:     start_x     <= pwdata[15:0];
        REG_START_Y:     start_y     <= pwdata[15:0];
        REG_REF_X:       ref_x       <= pwdata[15:0];
        REG_REF_Y:       ref_y       <= pwdata[15:0];
        REG_ANGLE_TOL:   angle_tol   <= pwdata[15:0];
        REG_DIST_MARGIN: dist_margin <= pwdata[15:0];
        REG_MISS_LIMIT:  miss_limit  <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (widx)
      REG_START_X:     prdata = {16'd0, start_x};
      REG_START_Y:     prdata = {16'd0, start_y};
      REG_REF_X:       prdata = {16'd0, ref_x};
      REG_REF_Y:       prdata = {16'd0, ref_y};
      REG_ANGLE_TOL:   prdata = {16'd0, angle_tol};
      REG_DIST_MARGIN: prdata = {16'd0, dist_margin};
      REG_MISS_LIMIT:  prdata = {28'd0, miss_limit};
      default:         prdata = '0;
    endcase
  end

  // ---------------- shared units ----------------
  assign cord_px = (state == ST_REF_GO) ? ref_x : cx;
  assign cord_py = (state == ST_REF_GO) ? ref_y : cy;
  assign cord_a  = $signed({1'b0, start_x}) - $signed({1'b0, cord_px});
  assign cord_b  = $signed({1'b0, start_y}) - $signed({1'b0, cord_py});

  always_comb begin
    priority if (state == ST_REF_GO) begin
      sq_x1 = start_x;
      sq_y1 = start_y;
      sq_x2 = ref_x;
      sq_y2 = ref_y;
    end else if (state == ST_CAND_GO) begin
      sq_x1 = cx;
      sq_y1 = cy;
      sq_x2 = last_x;
      sq_y2 = last_y;
    end else begin
      sq_x1 = best_x;
      sq_y1 = best_y;
      sq_x2 = last_x;
      sq_y2 = last_y;
    end
  end

  btcg_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cordic_start),
    .a     (cord_a),
    .b     (cord_b),
    .busy  (cordic_busy),
    .angle (cord_angle)
  );

  btcg_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sqrt_start),
    .x1    (sq_x1),
    .y1    (sq_y1),
    .x2    (sq_x2),
    .y2    (sq_y2),
    .busy  (sqrt_busy),
    .root  (sqrt_root)
  );

  assign units_idle = !cordic_busy && !sqrt_busy;

  // ---------------- median sweep ----------------
  // Entry j is the k-th smallest when fewer than k+1 entries lie below it and more
  // than k lie at or below it.
  assign sj = step_hist[med_idx];

  always_comb begin
    lt_cnt = '0;
    le_cnt = '0;
    for (int k = 0; k < STEP_WINDOW; k++) begin
      lt_cnt = lt_cnt + RK_W'(step_hist[k] < sj);
      le_cnt = le_cnt + RK_W'(step_hist[k] <= sj);
    end
  end

  assign med_last = (med_idx == SI_W'(STEP_WINDOW - 1));

  // ---------------- gates ----------------
  assign med   = (17'(med_lo) + 17'(med_hi)) >> 1;
  assign dz    = (ANG_W+1)'(cord_angle) - (ANG_W+1)'(zref);
  assign adz   = dz[ANG_W] ? (ANG_W+1)'(-dz) : (ANG_W+1)'(dz);
  assign g_top = (17'(cy) + 17'(TOP_MARGIN)) <= 17'(start_y);
  assign g_ang = adz <= (ANG_W+1)'({angle_tol, 8'd0});
  assign g_max = 17'(sqrt_root) <= 17'(dref) + 17'(dist_margin);
  assign g_med = (step_count <= SC_W'(STEP_WINDOW)) ||
                 (19'(sqrt_root) <= 19'(med[15:0] * STEP_FACTOR));
  assign g_rad = (mean_radius == 16'd0) || (17'(cr) <= 17'(mean_radius * RADIUS_FACTOR));
  assign g_y   = cy < last_y;
  assign keep  = cpres && g_top && g_ang && g_max && g_med && g_rad && g_y &&
                 (best_radius < cr);

  assign found = best_radius != 16'd0;
  assign lim   = (miss_limit == 4'd0) ? 4'd1 : miss_limit;
  assign over  = miss_count >= lim;

  // ---------------- mean radius ----------------
  always_comb begin
    rsum = '0;
    for (int i = 0; i < RADIUS_WINDOW; i++) begin
      rsum = rsum + SUM_W'(rad_hist[i]);
    end
  end

  // The reciprocal is rounded up with enough spare bits that the floor of the product
  // equals the floor of the quotient for every sum the window can hold.
  assign quot_prod = dv * DIV_RECIP;

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (item.valid && !halted) begin
          priority if (item.cand_present) begin
            state_next = ST_REF_GO;
          end else if (item.frame_end) begin
            state_next = ST_FEND;
          end
        end
      end
      ST_REF_GO:    state_next = ST_REF_WAIT;
      ST_REF_WAIT:  if (units_idle) state_next = ST_CAND_GO;
      ST_CAND_GO:   state_next = ST_CAND_WAIT;
      ST_CAND_WAIT: begin
        if (units_idle) begin
          state_next = (step_count > SC_W'(STEP_WINDOW)) ? ST_MED : ST_DECIDE;
        end
      end
      ST_MED:       if (med_last) state_next = ST_DECIDE;
      ST_DECIDE:    state_next = cfend ? ST_FEND : ST_IDLE;
      ST_FEND:      state_next = found ? ST_STEP_WAIT : ST_HIST;
      ST_STEP_WAIT: if (!sqrt_busy) state_next = ST_HIST;
      ST_HIST:      state_next = ST_SUM;
      ST_SUM: begin
        state_next = (radius_count >= RC_W'(RADIUS_WINDOW)) ? ST_DIV : ST_OUT;
      end
      ST_DIV:       state_next = ST_OUT;
      ST_OUT:       if (result_load) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    item.ready   = (state == ST_IDLE);
    cordic_start = (state == ST_REF_GO) || (state == ST_CAND_GO);
    sqrt_start   = cordic_start || ((state == ST_FEND) && found);
    result_load  = (state == ST_OUT) && (!result.valid || result.ready);
  end

  // ---------------- work registers ----------------
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && item.valid) begin
      cx    <= item.cand_x;
      cy    <= item.cand_y;
      cr    <= item.cand_radius;
      cpres <= item.cand_present;
      cfend <= item.frame_end;
    end
    if (state == ST_REF_WAIT && units_idle) begin
      zref <= cord_angle;
      dref <= sqrt_root;
    end
    if (state == ST_CAND_GO) begin
      med_idx <= '0;
    end
    if (state == ST_MED) begin
      med_idx <= med_idx + 1'b1;
      if (lt_cnt <= RK_W'(MID_LO) && RK_W'(MID_LO) < le_cnt) begin
        med_lo <= sj;
      end
      if (lt_cnt <= RK_W'(MID_HI) && RK_W'(MID_HI) < le_cnt) begin
        med_hi <= sj;
      end
    end
    if (state == ST_SUM) begin
      dv <= rsum;
    end
  end

  // ---------------- track state ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      last_x       <= '0;
      last_y       <= '0;
      step_count   <= '0;
      radius_count <= '0;
      mean_radius  <= '0;
      miss_count   <= '0;
      best_radius  <= '0;
      best_x       <= '0;
      best_y       <= '0;
      halted       <= 1'b0;
    end else if (wr_restart) begin
      last_x       <= (widx == REG_START_X) ? pwdata[15:0] : start_x;
      last_y       <= (widx == REG_START_Y) ? pwdata[15:0] : start_y;
      step_count   <= '0;
      radius_count <= '0;
      mean_radius  <= '0;
      miss_count   <= '0;
      best_radius  <= '0;
      best_x       <= '0;
      best_y       <= '0;
      halted       <= 1'b0;
    end else begin
      case (state)
        ST_DECIDE: begin
          if (keep) begin
            best_radius <= cr;
            best_x      <= cx;
            best_y      <= cy;
          end
        end
        ST_HIST: begin
          if (found) begin
            for (int i = STEP_WINDOW - 1; i > 0; i--) begin
              step_hist[i] <= step_hist[i-1];
            end
            step_hist[0] <= sqrt_root;
            if (step_count < SC_W'(STEP_WINDOW + 1)) begin
              step_count <= step_count + 1'b1;
            end
            for (int i = RADIUS_WINDOW - 1; i > 0; i--) begin
              rad_hist[i] <= rad_hist[i-1];
            end
            rad_hist[0] <= best_radius;
            if (radius_count < RC_W'(RADIUS_WINDOW)) begin
              radius_count <= radius_count + 1'b1;
            end
            miss_count <= '0;
            last_x     <= best_x;
            last_y     <= best_y;
          end else if (miss_count != MISS_MAX) begin
            miss_count <= miss_count + 4'd1;
          end
        end
        ST_DIV: begin
          mean_radius <= quot_prod[DIV_K +: 16];
        end
        ST_OUT: begin
          if (result_load) begin
            best_radius <= '0;
            best_x      <= '0;
            best_y      <= '0;
            halted      <= over;
          end
        end
        default: ;
      endcase
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (result_load) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result_load) begin
      result.track_x       <= last_x;
      result.track_y       <= last_y;
      result.ball_found    <= found;
      result.chosen_radius <= best_radius;
      result.tracking_over <= over;
    end
  end

  // ---------------- checks ----------------
  `BTCG_ASSERT(a_units_idle, clk, rst, (state == ST_IDLE) |-> units_idle, "unit busy in idle")
  `BTCG_ASSERT_NEXT(a_halt_drop, clk, rst, item.valid && item.ready && halted && !wr_restart, state == ST_IDLE, "halted item not dropped")
  `BTCG_ASSERT_NEXT(a_best_clear, clk, rst, result_load, best_radius == 16'd0, "best not cleared after result")

endmodule
